@@ src/tpa_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the triangle primitive assembler
// no dependencies
package tpa_pkg;

    localparam int unsigned INDEX_W  = 32;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;

    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [1:0]         fill_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PRIM_MODE = 1'b0
    } reg_idx_t;

    typedef enum logic {
        MODE_LIST  = 1'b0,
        MODE_STRIP = 1'b1
    } prim_mode_t;

    localparam fill_t FILL_FULL = 2'd2;

endpackage

@@ src/tpa_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for index input and triangle output
// depends on tpa_pkg
interface tpa_index_if;
    import tpa_pkg::*;

    logic   valid;
    logic   ready;
    index_t vertex_index;
    logic   index_last;

    modport source (output valid, output vertex_index, output index_last, input ready);
    modport sink   (input valid, input vertex_index, input index_last, output ready);
endinterface

interface tpa_tri_if;
    import tpa_pkg::*;

    logic   valid;
    logic   ready;
    logic   tri_valid;
    index_t corner_a;
    index_t corner_b;
    index_t corner_c;
    logic   mesh_end;

    modport source (output valid, output tri_valid, output corner_a, output corner_b,
                    output corner_c, output mesh_end, input ready);
    modport sink   (input valid, input tri_valid, input corner_a, input corner_b,
                    input corner_c, input mesh_end, output ready);
endinterface

@@ src/triangle_primitive_assembler.sv @@
`timescale 1ns / 1ps
// output: a triangle transaction is registered and appears in the cycle after its index is accepted
// throughput: one index per clock, limited only by the single output register
// the output register frees when taken, so input is accepted while a result is taken
// reset: window, fill count, parity and output valid clear; prim_mode resets to list
// depends on tpa_pkg and tpa_if
module triangle_primitive_assembler
(
    input  logic                         clk,
    input  logic                         rst_n,
    tpa_index_if.sink                    idx_in,
    tpa_tri_if.source                    tri_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpa_pkg::APB_DW-1:0]   pwdata,
    output logic [tpa_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import tpa_pkg::*;

    prim_mode_t prim_mode_reg;
    index_t     older_reg, older_next;
    index_t     newer_reg, newer_next;
    fill_t      fill_count_reg, fill_count_next;
    logic       odd_reg, odd_next;

    logic       out_valid_reg;
    logic       tri_valid_reg, tri_valid_next;
    index_t     corner_a_reg, corner_a_next;
    index_t     corner_b_reg, corner_b_next;
    index_t     corner_c_reg, corner_c_next;
    logic       mesh_end_reg;

    logic       in_take;
    logic       formed;
    logic       distinct;
    logic       cfg_write;
    index_t     b_raw, c_raw;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_PRIM_MODE)
                       ? {{(APB_DW-1){1'b0}}, prim_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_mode_reg <= MODE_LIST;
        end
        else if (cfg_write && paddr[PADDR_W-1:2] == REG_PRIM_MODE)
        begin
            prim_mode_reg <= prim_mode_t'(pwdata[0]);
        end
    end

    assign idx_in.ready = !out_valid_reg || tri_out.ready;
    assign in_take      = idx_in.valid && idx_in.ready;

    always_comb
    begin
        formed = (fill_count_reg >= FILL_FULL);
        b_raw  = newer_reg;
        c_raw  = idx_in.vertex_index;
        if (prim_mode_reg == MODE_STRIP && odd_reg)
        begin
            b_raw = idx_in.vertex_index;
            c_raw = newer_reg;
        end
        distinct = (older_reg != newer_reg) && (older_reg != idx_in.vertex_index)
                   && (newer_reg != idx_in.vertex_index);

        tri_valid_next = formed && distinct;
        corner_a_next  = tri_valid_next ? older_reg : '0;
        corner_b_next  = tri_valid_next ? b_raw : '0;
        corner_c_next  = tri_valid_next ? c_raw : '0;

        older_next      = older_reg;
        newer_next      = newer_reg;
        fill_count_next = fill_count_reg;
        case (prim_mode_reg)
            MODE_STRIP:
            begin
                older_next = newer_reg;
                newer_next = idx_in.vertex_index;
                if (!formed)
                begin
                    fill_count_next = fill_count_reg + 2'd1;
                end
            end
            default:
            begin
                if (formed)
                begin
                    fill_count_next = '0;
                end
                else
                begin
                    older_next      = newer_reg;
                    newer_next      = idx_in.vertex_index;
                    fill_count_next = fill_count_reg + 2'd1;
                end
            end
        endcase
        odd_next = !odd_reg;

        if (idx_in.index_last)
        begin
            older_next      = '0;
            newer_next      = '0;
            fill_count_next = '0;
            odd_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg      <= '0;
            newer_reg      <= '0;
            fill_count_reg <= '0;
            odd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                older_reg      <= older_next;
                newer_reg      <= newer_next;
                fill_count_reg <= fill_count_next;
                odd_reg        <= odd_next;
                out_valid_reg  <= 1'b1;
            end
            else if (tri_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tri_valid_reg <= tri_valid_next;
            corner_a_reg  <= corner_a_next;
            corner_b_reg  <= corner_b_next;
            corner_c_reg  <= corner_c_next;
            mesh_end_reg  <= idx_in.index_last;
        end
    end

    assign tri_out.valid     = out_valid_reg;
    assign tri_out.tri_valid = tri_valid_reg;
    assign tri_out.corner_a  = corner_a_reg;
    assign tri_out.corner_b  = corner_b_reg;
    assign tri_out.corner_c  = corner_c_reg;
    assign tri_out.mesh_end  = mesh_end_reg;

`ifndef SYNTH
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg != 2'd3)
        else $error("fill count out of range");

    a_tri_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tri_valid_reg |->
            corner_a_reg != corner_b_reg && corner_a_reg != corner_c_reg
            && corner_b_reg != corner_c_reg)
        else $error("emitted triangle has equal corners");

    a_no_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !tri_valid_reg |->
            corner_a_reg == '0 && corner_b_reg == '0 && corner_c_reg == '0)
        else $error("corners not cleared without triangle");

    a_mesh_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && idx_in.index_last |=>
            fill_count_reg == '0 && !odd_reg && older_reg == '0 && newer_reg == '0)
        else $error("window not cleared after mesh end");

    a_list_group: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && prim_mode_reg == MODE_LIST && fill_count_reg == FILL_FULL |=>
            fill_count_reg == '0)
        else $error("list group did not restart");
`endif

endmodule

@@ sim/triangle_primitive_assembler_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for triangle_primitive_assembler: directed table, then random meshes
// depends on tpa_pkg, tpa_if and the triangle_primitive_assembler rtl
module triangle_primitive_assembler_tb;
    import tpa_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 125;
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned MAX_REPORTS     = 40;
    localparam logic [PADDR_W-1:0] PRIM_MODE_ADDR = {REG_PRIM_MODE, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR     = 3'd4;

    typedef struct packed {
        logic   tri_valid;
        index_t corner_a;
        index_t corner_b;
        index_t corner_c;
        logic   mesh_end;
    } tri_rec_t;

    typedef struct {
        prim_mode_t mode;
        index_t     vi;
        logic       last;
        logic       pinned;
        tri_rec_t   want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic pready;

    tpa_index_if idx_if();
    tpa_tri_if   tri_if();

    triangle_primitive_assembler u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx_in  (idx_if.sink),
        .tri_out (tri_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    prim_mode_t asm_mode;
    index_t     win_older;
    index_t     win_newer;
    fill_t      win_fill;
    logic       win_odd;

    tri_rec_t   tri_expect_q[$];
    dir_row_t   directed_rows[$];
    logic       pin_en;
    tri_rec_t   pin_val;
    int         src_idle_pct;
    int         snk_idle_pct;
    int         err_count;
    int         stall_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic tri_rec_t assemble_triangle(input index_t vi, input logic last);
        tri_rec_t res;
        index_t   tmp;
        logic     formed;
        res = '0;
        formed = (win_fill >= FILL_FULL);
        res.corner_a = win_older;
        res.corner_b = win_newer;
        res.corner_c = vi;
        if (formed && asm_mode == MODE_STRIP && win_odd)
        begin
            tmp = res.corner_b;
            res.corner_b = res.corner_c;
            res.corner_c = tmp;
        end
        if (asm_mode == MODE_STRIP)
        begin
            win_older = win_newer;
            win_newer = vi;
            if (win_fill < FILL_FULL)
                win_fill = win_fill + 1'b1;
        end
        else if (win_fill >= FILL_FULL)
        begin
            win_fill = '0;
        end
        else
        begin
            win_older = win_newer;
            win_newer = vi;
            win_fill = win_fill + 1'b1;
        end
        win_odd = ~win_odd;
        if (last)
        begin
            win_older = '0;
            win_newer = '0;
            win_fill  = '0;
            win_odd   = 1'b0;
        end
        if (formed && res.corner_a != res.corner_b && res.corner_a != res.corner_c
            && res.corner_b != res.corner_c)
            res.tri_valid = 1'b1;
        else
            res = '0;
        res.mesh_end = last;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // predictor, scoreboard and register shadow
    always @(posedge clk or negedge rst_n)
    begin : monitor
        tri_rec_t pred;
        tri_rec_t want;
        tri_rec_t got;
        if (!rst_n)
        begin
            asm_mode  = MODE_LIST;
            win_older = '0;
            win_newer = '0;
            win_fill  = '0;
            win_odd   = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == PRIM_MODE_ADDR)
                asm_mode = prim_mode_t'(pwdata[0]);
            if (idx_if.valid && idx_if.ready)
            begin
                pred = assemble_triangle(idx_if.vertex_index, idx_if.index_last);
                tri_expect_q.insert(tri_expect_q.size(), pin_en ? pin_val : pred);
            end
            if (tri_if.valid && tri_if.ready)
            begin
                got.tri_valid = tri_if.tri_valid;
                got.corner_a  = tri_if.corner_a;
                got.corner_b  = tri_if.corner_b;
                got.corner_c  = tri_if.corner_c;
                got.mesh_end  = tri_if.mesh_end;
                if (tri_expect_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected transaction, expected none, actual %h",
                                 $time, got);
                end
                else
                begin
                    want = tri_expect_q.pop_front();
                    if (got.tri_valid !== want.tri_valid)
                        note_mismatch("tri_valid", want.tri_valid, got.tri_valid);
                    if (got.corner_a !== want.corner_a)
                        note_mismatch("corner_a", want.corner_a, got.corner_a);
                    if (got.corner_b !== want.corner_b)
                        note_mismatch("corner_b", want.corner_b, got.corner_b);
                    if (got.corner_c !== want.corner_c)
                        note_mismatch("corner_c", want.corner_c, got.corner_c);
                    if (got.mesh_end !== want.mesh_end)
                        note_mismatch("mesh_end", want.mesh_end, got.mesh_end);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            tri_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (idx_if.valid && idx_if.ready) || (tri_if.valid && tri_if.ready) || psel)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_index(input index_t vi, input logic last, input logic pinned,
                              input tri_rec_t want);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            idx_if.valid        <= 1'b0;
            idx_if.vertex_index <= $urandom;
            idx_if.index_last   <= 1'($urandom_range(1));
            @(negedge clk);
        end
        idx_if.valid        <= 1'b1;
        idx_if.vertex_index <= vi;
        idx_if.index_last   <= last;
        pin_en              <= pinned;
        pin_val             <= want;
        @(posedge clk);
        while (!idx_if.ready)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk);
        idx_if.valid <= 1'b0;
        while (tri_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_prim_mode(input logic [APB_DW-1:0] wdata);
        logic [APB_DW-1:0] rd;
        drain_results();
        apb_access(1'b1, PRIM_MODE_ADDR, wdata, rd);
        apb_access(1'b0, PRIM_MODE_ADDR, '0, rd);
        if (rd !== {{(APB_DW-1){1'b0}}, asm_mode})
        begin
            err_count++;
            $display("%0t: prim_mode readback mismatch, expected %h, actual %h",
                     $time, {{(APB_DW-1){1'b0}}, asm_mode}, rd);
        end
    endtask

    task automatic add_row(input prim_mode_t mode, input index_t vi, input logic last,
                           input logic pinned, input index_t a, input index_t b,
                           input index_t c);
        dir_row_t r;
        r.mode   = mode;
        r.vi     = vi;
        r.last   = last;
        r.pinned = pinned;
        r.want.tri_valid = (a != 0 || b != 0 || c != 0);
        r.want.corner_a  = a;
        r.want.corner_b  = b;
        r.want.corner_c  = c;
        r.want.mesh_end  = last;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    function automatic index_t pick_index(input index_t base);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return base + $urandom_range(15);
            5, 6, 7:       return $urandom;
            default:       return $urandom_range(1) ? '1 : index_t'($urandom_range(1));
        endcase
    endfunction

    initial
    begin
        logic [APB_DW-1:0] rd;
        logic [APB_DW-1:0] wval;
        int                sent;
        int                mesh_len;
        index_t            base;

        rst_n               = 1'b0;
        idx_if.valid        = 1'b0;
        idx_if.vertex_index = '0;
        idx_if.index_last   = 1'b0;
        tri_if.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pin_en              = 1'b0;
        pin_val             = '0;
        src_idle_pct        = 20;
        snk_idle_pct        = 53;
        err_count           = 0;
        stall_cycles        = 0;

        // list mode from reset, extremes, degenerate group, dropped partial group
        add_row(MODE_LIST,  32'd5,          1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd6,          1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd7,          1'b0, 1'b1, 32'd5,          32'd6,  32'd7);
        add_row(MODE_LIST,  32'hFFFF_FFFF,  1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd0,          1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd1,          1'b1, 1'b1, 32'hFFFF_FFFF,  32'd0,  32'd1);
        add_row(MODE_LIST,  32'd9,          1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd9,          1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd4,          1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd2,          1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd3,          1'b1, 1'b1, 32'd0,          32'd0,  32'd0);
        // strip mode with winding swap on odd positions
        add_row(MODE_STRIP, 32'd10,         1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_STRIP, 32'd11,         1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        add_row(MODE_STRIP, 32'd12,         1'b0, 1'b1, 32'd10,         32'd11, 32'd12);
        add_row(MODE_STRIP, 32'd13,         1'b0, 1'b1, 32'd11,         32'd13, 32'd12);
        add_row(MODE_STRIP, 32'd11,         1'b0, 1'b1, 32'd12,         32'd13, 32'd11);
        add_row(MODE_STRIP, 32'd12,         1'b0, 1'b1, 32'd13,         32'd12, 32'd11);
        add_row(MODE_STRIP, 32'd12,         1'b0, 1'b1, 32'd0,          32'd0,  32'd0);
        // mode changes inside a mesh
        add_row(MODE_LIST,  32'd20,         1'b0, 1'b0, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd21,         1'b0, 1'b0, 32'd0,          32'd0,  32'd0);
        add_row(MODE_LIST,  32'd22,         1'b0, 1'b0, 32'd0,          32'd0,  32'd0);
        add_row(MODE_STRIP, 32'd23,         1'b0, 1'b0, 32'd0,          32'd0,  32'd0);
        add_row(MODE_STRIP, 32'd24,         1'b0, 1'b0, 32'd0,          32'd0,  32'd0);
        add_row(MODE_STRIP, 32'd25,         1'b1, 1'b0, 32'd0,          32'd0,  32'd0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a write outside the register map must leave the mode alone
        apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FFFF, rd);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != asm_mode)
                set_prim_mode(directed_rows[i].mode == MODE_STRIP ? 32'hFFFF_FFFF
                                                                  : 32'hFFFF_FFFE);
            send_index(directed_rows[i].vi, directed_rows[i].last, directed_rows[i].pinned,
                       directed_rows[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 53 : 0;
            snk_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 20 : 0;
            wval = $urandom;
            wval[0] = (ph % 2 == 0) ? MODE_STRIP : MODE_LIST;
            set_prim_mode(wval);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                mesh_len = $urandom_range(1, 12);
                base = $urandom;
                for (int k = 0; k < mesh_len; k++)
                begin
                    if (k != 0 && $urandom_range(39) == 0)
                    begin
                        wval = $urandom;
                        wval[0] = ~asm_mode;
                        set_prim_mode(wval);
                    end
                    send_index(pick_index(base), k == mesh_len - 1, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && tri_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
